[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the prefix-code decoder.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: expr");
// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/pctd_pkg.sv]
// Package for the prefix-code table decoder: word types, action codes, defaults.
// No dependencies; used by pctd_table_mem and prefix_code_table_decoder_top.
package pctd_pkg;

    localparam int DEF_TABLE_DEPTH  = 256;
    localparam int DEF_MAX_CODE_LEN = 32;

    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 8;
    localparam int SYMBOL_W   = 8;
    localparam int CODE_W     = 32;
    localparam int LENGTH_W   = 6;
    localparam int CFG_W      = 9;

    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DECODE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  entry_index;
        logic [SYMBOL_W-1:0] entry_symbol;
        logic [CODE_W-1:0]   entry_code;
        logic [LENGTH_W-1:0] entry_length;
        logic                code_bit;
    } t_in_word;

    typedef struct packed {
        logic                symbol_valid;
        logic [SYMBOL_W-1:0] symbol;
        logic                overflow;
    } t_out_word;

    // one stored table entry
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic [CODE_W-1:0]   code;
        logic [LENGTH_W-1:0] length;
    } t_entry;

endpackage

[hw/rtl/pctd_table_mem.sv]
// Code table memory: one write port, one read port, registered read data.
// Depends on pctd_pkg (t_entry).
module pctd_table_mem #(
    parameter int DEPTH = pctd_pkg::DEF_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  pctd_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output pctd_pkg::t_entry o_rd_data
);

    pctd_pkg::t_entry r_mem [DEPTH];
    pctd_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/prefix_code_table_decoder_top.sv]
// Prefix-code table decoder, top level. Depends on pctd_pkg, pctd_table_mem.
// Load and clear words are done when accepted. A decode word reads N table entries in turn,
// N = min(entries_in_use, TABLE_DEPTH), one table entry read per cycle, until a hit. A result
// word (hit, or overflow at MAX_CODE_LEN bits) is valid as the input reopens.
// Throughput: one word at a time; a full, stalled output register holds the scan.
// Sync active-low reset clears accumulator, entries_in_use, control; table is not reset.
`include "assert_macros.svh"
module prefix_code_table_decoder_top #(
    parameter int TABLE_DEPTH  = pctd_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_CODE_LEN = pctd_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input word channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pctd_pkg::t_in_word         i_in_word,
    // result word channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pctd_pkg::t_out_word        o_out_word,
    // entries_in_use register write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pctd_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);   // scan counter, reaches depth
    localparam int LW   = $clog2(MAX_CODE_LEN + 1);  // accumulated length
    localparam int CMPW = (LW > pctd_pkg::LENGTH_W) ? LW : pctd_pkg::LENGTH_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // ---------------------------------------------------------------- registers
    logic                               r_state,    n_state;
    logic [pctd_pkg::CFG_W-1:0]         r_eiu;
    logic [CW-1:0]                      r_count,    n_count;
    logic [CW-1:0]                      r_scan_idx, n_scan_idx;
    logic                               r_pend,     n_pend;
    logic [pctd_pkg::CODE_W-1:0]        r_acc_bits, n_acc_bits;
    logic [LW-1:0]                      r_acc_len,  n_acc_len;
    logic                               r_out_valid, n_out_valid;
    pctd_pkg::t_out_word                r_out,      n_out;

    // ---------------------------------------------------------------- memory
    logic             wr_en;
    logic             rd_en;
    pctd_pkg::t_entry wr_data;
    pctd_pkg::t_entry rd_data;

    logic in_accept;
    logic slot_free;
    logic idx_in_range;
    logic reads_done;
    logic hit;
    logic at_end;
    logic emit;
    logic load_out;
    logic [pctd_pkg::CODE_W-1:0] code_mask;

    // config port always ready; the user must write only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eiu <= '0;
        end else if (i_cfg_valid) begin
            r_eiu <= i_cfg_data;
        end
    end

    // new words only in idle, so table writes never meet scan reads
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign idx_in_range = ({1'b0, i_in_word.entry_index} < 9'(TABLE_DEPTH));
    assign wr_en        = in_accept && (i_in_word.action == pctd_pkg::ACT_LOAD) && idx_in_range;
    assign wr_data.symbol = i_in_word.entry_symbol;
    assign wr_data.code   = i_in_word.entry_code;
    assign wr_data.length = i_in_word.entry_length;

    assign reads_done = (r_scan_idx == r_count);
    assign slot_free  = !r_out_valid || !i_out_stall;

    // entry compare: nonzero length up to 32, equal to accumulated length,
    // masked code equal to accumulated bits
    assign code_mask = ~({pctd_pkg::CODE_W{1'b1}} << rd_data.length);
    assign hit = r_pend
              && (rd_data.length != '0)
              && (rd_data.length <= pctd_pkg::LENGTH_W'(pctd_pkg::CODE_W))
              && (CMPW'(rd_data.length) == CMPW'(r_acc_len))
              && ((rd_data.code & code_mask) == r_acc_bits);
    assign at_end = !r_pend && reads_done;
    assign emit   = hit || (at_end && (r_acc_len == LW'(MAX_CODE_LEN)));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan_idx  = r_scan_idx;
        n_pend      = r_pend;
        n_acc_bits  = r_acc_bits;
        n_acc_len   = r_acc_len;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        rd_en       = 1'b0;
        load_out    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_word.action == pctd_pkg::ACT_DECODE) begin
                        n_acc_bits = {r_acc_bits[pctd_pkg::CODE_W-2:0], i_in_word.code_bit};
                        n_acc_len  = r_acc_len + LW'(1);
                        n_count    = (r_eiu > pctd_pkg::CFG_W'(TABLE_DEPTH))
                                   ? CW'(TABLE_DEPTH) : CW'(r_eiu);
                        n_scan_idx = '0;
                        n_pend     = 1'b0;
                        n_state    = S_SCAN;
                    end else if (i_in_word.action == pctd_pkg::ACT_CLEAR) begin
                        n_acc_bits = '0;
                        n_acc_len  = '0;
                    end
                end
            end
            S_SCAN: begin
                if (hit || at_end) begin
                    if (!emit) begin
                        n_state = S_IDLE;
                    end else if (slot_free) begin
                        load_out           = 1'b1;
                        n_out_valid        = 1'b1;
                        n_out.symbol_valid = hit;
                        n_out.symbol       = hit ? rd_data.symbol : '0;
                        n_out.overflow     = !hit;
                        n_acc_bits         = '0;
                        n_acc_len          = '0;
                        n_pend             = 1'b0;
                        n_state            = S_IDLE;
                    end
                    // else hold: no read issued, read data stays put
                end else begin
                    rd_en      = !reads_done;
                    n_pend     = !reads_done;
                    n_scan_idx = reads_done ? r_scan_idx : r_scan_idx + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan_idx  <= '0;
            r_pend      <= 1'b0;
            r_acc_bits  <= '0;
            r_acc_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan_idx  <= n_scan_idx;
            r_pend      <= n_pend;
            r_acc_bits  <= n_acc_bits;
            r_acc_len   <= n_acc_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    pctd_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in_word.entry_index[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_scan_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------- checks
    `ASSERT_ALWAYS(a_no_rw_overlap, i_clk, i_rst_n, !(wr_en && rd_en))
    `ASSERT_ALWAYS(a_acc_len_max, i_clk, i_rst_n, r_acc_len <= LW'(MAX_CODE_LEN))
    `ASSERT_ALWAYS(a_out_kind, i_clk, i_rst_n, !r_out_valid || (r_out.symbol_valid != r_out.overflow))
    `ASSERT_NEXT(a_clear_on_result, i_clk, i_rst_n, load_out, (r_acc_len == '0) && (r_state == S_IDLE))

endmodule
